// ===== rtl/core/efd_pkg.sv =====
package efd_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 32;

    localparam int BYTE_W    = 8;
    localparam int RAW_W     = 32;
    localparam int TURN_W    = 15;
    localparam int ANGLE_W   = 17;
    localparam int CHAN_W    = 5;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int GLOB_W    = 9;

    localparam int FRAME_LEN = 7;
    localparam int HOLD_LEN  = FRAME_LEN - 1;

    localparam logic [BYTE_W-1:0] FRAME_HEAD = 8'h7E;
    localparam logic [BYTE_W-1:0] FRAME_TAIL = 8'h7F;

    localparam logic CMD_RX_BYTE = 1'b0;
    localparam logic CMD_QUERY   = 1'b1;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_CHAN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_LIMIT = 1'b1;

    localparam logic [CFG_W-1:0] BASE_CHAN_RESET  = 8'd0;
    localparam logic [CFG_W-1:0] CHAN_LIMIT_RESET = 8'd10;

    typedef struct packed {
        logic              hit;
        logic [BYTE_W-1:0] chan;
        logic [RAW_W-1:0]  raw;
    } frame_t;

endpackage

// ===== rtl/core/efd_in_if.sv =====
interface efd_in_if;
    logic                            valid;
    logic                            ready;
    logic                            command;
    logic [efd_pkg::BYTE_W-1:0]      rx_byte;
    logic [efd_pkg::CHAN_W-1:0]      query_channel;

    modport source (output valid, output command, output rx_byte, output query_channel,
                    input ready);
    modport sink (input valid, input command, input rx_byte, input query_channel,
                  output ready);
endinterface

// ===== rtl/core/efd_out_if.sv =====
interface efd_out_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [efd_pkg::CHAN_W-1:0]      table_channel;
    logic [efd_pkg::RAW_W-1:0]       raw_word;
    logic [efd_pkg::TURN_W-1:0]      turn_count;
    logic [efd_pkg::ANGLE_W-1:0]     angle_position;
    logic                            reading_valid;

    modport source (output valid, output kind, output table_channel, output raw_word,
                    output turn_count, output angle_position, output reading_valid,
                    input ready);
    modport sink (input valid, input kind, input table_channel, input raw_word,
                  input turn_count, input angle_position, input reading_valid,
                  output ready);
endinterface

// ===== rtl/core/encoder_frame_deframer.sv =====
// Channel   Dir  Beat contents
// in_ch     in   command, rx_byte, query_channel
// out_ch    out  kind, table_channel, raw_word, turn_count, angle_position, reading_valid
// cfg       in   cfg_we, cfg_index, cfg_data (0 base channel, 1 channel limit)
//
// One input beat is taken every cycle unless a stall holds the middle stage; the frame check on
// the seven-byte window and the single write port of the reading table settle that rate.
// A result passes the middle stage, then the output register; the table's read is registered.
// Reset clears the window fill, the valid flags and the pipeline at once; no clearing pass.
// A stalled result holds in the output register while one more beat moves into the middle stage.
module encoder_frame_deframer #(
    parameter int TABLE_DEPTH = efd_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    efd_in_if.sink                        in_ch,
    efd_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [efd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [efd_pkg::CFG_W-1:0]     cfg_data
);
    import efd_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [CFG_W-1:0]  offset_reg;
    logic [CFG_W-1:0]  count_reg;

    frame_t            frame;
    logic              in_fire;
    logic              byte_en;
    logic              query;
    logic [GLOB_W-1:0] glob;
    logic [GLOB_W-1:0] query_ext;
    logic              store_en;
    logic              query_in_range;
    logic [RAW_W-1:0]  tbl_data;
    logic              tbl_valid;

    logic              s1_valid_reg;
    logic              s1_kind_reg;
    logic [CHAN_W-1:0] s1_chan_reg;
    logic [RAW_W-1:0]  s1_raw_reg;
    logic              s1_adv;

    logic              out_valid_reg;
    logic              out_kind_reg;
    logic [CHAN_W-1:0] out_chan_reg;
    logic [RAW_W-1:0]  out_raw_reg;
    logic              out_rv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= BASE_CHAN_RESET;
            count_reg  <= CHAN_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BASE_CHAN:  offset_reg <= cfg_data;
                CFG_CHAN_LIMIT: count_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign s1_adv      = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !s1_valid_reg || s1_adv;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign query       = in_fire && (in_ch.command == CMD_QUERY);
    assign byte_en     = in_fire && (in_ch.command == CMD_RX_BYTE);

    efd_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (byte_en),
        .byte_in (in_ch.rx_byte),
        .frame   (frame)
    );

    assign glob           = {1'b0, offset_reg} + {1'b0, frame.chan};
    assign store_en       = frame.hit && (frame.chan < count_reg)
                            && (glob < GLOB_W'(TABLE_DEPTH));
    assign query_ext      = GLOB_W'(in_ch.query_channel);
    assign query_in_range = query_ext < GLOB_W'(TABLE_DEPTH);

    efd_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (store_en),
        .wr_addr     (glob[ADDR_W-1:0]),
        .wr_data     (frame.raw),
        .rd_en       (query),
        .rd_addr     (query_ext[ADDR_W-1:0]),
        .rd_in_range (query_in_range),
        .rd_data     (tbl_data),
        .rd_valid    (tbl_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                s1_valid_reg <= query || store_en;
            end
            if (s1_valid_reg && s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg <= query ? KIND_QUERY : KIND_FRAME;
            s1_chan_reg <= query ? in_ch.query_channel : glob[CHAN_W-1:0];
            s1_raw_reg  <= frame.raw;
        end
        if (s1_valid_reg && s1_adv)
        begin
            out_kind_reg <= s1_kind_reg;
            out_chan_reg <= s1_chan_reg;
            out_raw_reg  <= (s1_kind_reg == KIND_QUERY) ? tbl_data : s1_raw_reg;
            out_rv_reg   <= (s1_kind_reg == KIND_QUERY) ? tbl_valid : 1'b1;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.kind           = out_kind_reg;
    assign out_ch.table_channel  = out_chan_reg;
    assign out_ch.raw_word       = out_raw_reg;
    assign out_ch.turn_count     = out_raw_reg[RAW_W-1:ANGLE_W];
    assign out_ch.angle_position = out_raw_reg[ANGLE_W-1:0];
    assign out_ch.reading_valid  = out_rv_reg;

    a_query_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
        query |=> (s1_valid_reg && (s1_kind_reg == KIND_QUERY)))
        else $error("accepted query did not reach the middle stage");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_raw_reg)
                                       && $stable(s1_chan_reg)))
        else $error("middle stage changed while stalled");

    a_frame_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == KIND_FRAME)) |-> out_rv_reg)
        else $error("stored frame result without reading_valid");

    a_store_only_on_byte: assert property (@(posedge clk) disable iff (!rst_n)
        store_en |-> byte_en)
        else $error("table write without an accepted byte");

endmodule

// ===== rtl/core/efd_ram.sv =====
module efd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/efd_window.sv =====
module efd_window (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       byte_en,
    input  logic [efd_pkg::BYTE_W-1:0] byte_in,
    output efd_pkg::frame_t            frame
);
    import efd_pkg::*;

    logic [BYTE_W-1:0] win_reg  [0:HOLD_LEN-1];
    logic [BYTE_W-1:0] win_next [0:HOLD_LEN-1];
    logic [2:0]        fill_reg;
    logic [2:0]        fill_next;
    logic [BYTE_W-1:0] full_win [0:FRAME_LEN-1];
    logic              full;
    logic              found;
    logic [2:0]        head;
    logic [2:0]        shift;
    logic [3:0]        src;

    always_comb
    begin
        for (int i = 0; i < HOLD_LEN; i++)
        begin
            full_win[i] = win_reg[i];
        end
        full_win[FRAME_LEN-1] = byte_in;
        full = byte_en && (fill_reg == 3'(HOLD_LEN));

        found = 1'b0;
        head  = 3'd0;
        for (int i = FRAME_LEN - 1; i >= 0; i--)
        begin
            if (full_win[i] == FRAME_HEAD)
            begin
                found = 1'b1;
                head  = 3'(i);
            end
        end

        if (!found)
        begin
            shift = 3'(FRAME_LEN);
        end
        else if (head != 3'd0)
        begin
            shift = head;
        end
        else if (full_win[FRAME_LEN-1] != FRAME_TAIL)
        begin
            shift = 3'd1;
        end
        else
        begin
            shift = 3'(FRAME_LEN);
        end

        frame.hit  = full && found && (head == 3'd0) && (full_win[FRAME_LEN-1] == FRAME_TAIL);
        frame.chan = full_win[1];
        frame.raw  = {full_win[2], full_win[3], full_win[4], full_win[5]};

        win_next  = win_reg;
        fill_next = fill_reg;
        src       = 4'd0;
        if (full)
        begin
            for (int i = 0; i < HOLD_LEN; i++)
            begin
                src = 4'(i) + {1'b0, shift};
                win_next[i] = (src < 4'(FRAME_LEN)) ? full_win[src[2:0]] : '0;
            end
            fill_next = 3'(FRAME_LEN) - shift;
        end
        else if (byte_en)
        begin
            win_next[fill_reg] = byte_in;
            fill_next = fill_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 3'd0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

// ===== rtl/core/efd_table.sv =====
module efd_table #(
    parameter int TABLE_DEPTH = efd_pkg::TABLE_DEPTH_DEFAULT,
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [efd_pkg::RAW_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    input  logic                      rd_in_range,
    output logic [efd_pkg::RAW_W-1:0] rd_data,
    output logic                      rd_valid
);
    import efd_pkg::*;

    logic [TABLE_DEPTH-1:0] flags_reg;
    logic                   rd_flag_reg;
    logic [RAW_W-1:0]       ram_q;

    efd_ram #(
        .WIDTH (RAW_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg   <= '0;
            rd_flag_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                flags_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_flag_reg <= rd_in_range && flags_reg[rd_addr];
            end
        end
    end

    // Entries never written, and reads out of range, read as zero.
    assign rd_data  = rd_flag_reg ? ram_q : '0;
    assign rd_valid = rd_flag_reg;

endmodule

// ===== tb/tb_encoder_frame_deframer.sv =====
module tb_encoder_frame_deframer;
    import efd_pkg::*;

    localparam int TABLE_DEPTH = TABLE_DEPTH_DEFAULT;
    localparam int PHASES = 6;
    localparam int PHASE_BEATS = 190;
    localparam int MAX_REPORTS = 40;

    typedef struct {
        logic         kind;
        logic [4:0]   chan;
        logic [31:0]  raw;
        logic [14:0]  turn;
        logic [16:0]  angle;
        logic         valid;
    } reading_t;

    class deframe_predictor;
        logic [7:0]  window [FRAME_LEN];
        int          fill;
        logic [31:0] store [TABLE_DEPTH];
        logic        flags [TABLE_DEPTH];
        logic [7:0]  offset;
        logic [7:0]  count;
        reading_t    pending_readings [$];
        int          errors;

        function new();
            foreach (window[i])
                window[i] = 8'h00;
            foreach (store[i])
            begin
                store[i] = 32'h0;
                flags[i] = 1'b0;
            end
            fill = 0;
            offset = BASE_CHAN_RESET;
            count = CHAN_LIMIT_RESET;
            errors = 0;
        endfunction

        function reading_t form_reading(logic kind, logic [4:0] chan, logic [31:0] raw,
                                        logic valid);
            reading_t r;
            r.kind = kind;
            r.chan = chan;
            r.raw = raw;
            r.turn = raw[31:17];
            r.angle = raw[16:0];
            r.valid = valid;
            return r;
        endfunction

        function void shift_out(int n);
            for (int i = 0; i < FRAME_LEN; i++)
                window[i] = (i + n < FRAME_LEN) ? window[i + n] : 8'h00;
            fill = FRAME_LEN - n;
        endfunction

        function void take_beat(logic cmd, logic [7:0] b, logic [4:0] q);
            int          head;
            int          glob;
            logic [7:0]  ch;
            logic [31:0] raw;
            if (cmd == CMD_QUERY)
            begin
                pending_readings.insert(pending_readings.size(),
                                        form_reading(KIND_QUERY, q, store[q], flags[q]));
                return;
            end
            window[fill] = b;
            fill++;
            if (fill < FRAME_LEN)
                return;
            head = FRAME_LEN;
            for (int i = FRAME_LEN - 1; i >= 0; i--)
                if (window[i] == FRAME_HEAD)
                    head = i;
            if (head == FRAME_LEN)
            begin
                shift_out(FRAME_LEN);
                return;
            end
            if (head > 0)
            begin
                shift_out(head);
                return;
            end
            if (window[FRAME_LEN - 1] != FRAME_TAIL)
            begin
                shift_out(1);
                return;
            end
            ch = window[1];
            raw = {window[2], window[3], window[4], window[5]};
            shift_out(FRAME_LEN);
            if (ch >= count)
                return;
            glob = int'(offset) + int'(ch);
            if (glob >= TABLE_DEPTH)
                return;
            store[glob] = raw;
            flags[glob] = 1'b1;
            pending_readings.insert(pending_readings.size(),
                                    form_reading(KIND_FRAME, glob[4:0], raw, 1'b1));
        endfunction

        function void flag_field(string name, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            if (pending_readings.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected beat, channel %0d raw %h", $time, got.chan,
                             got.raw);
                return;
            end
            want = pending_readings.pop_front();
            if (got.kind !== want.kind)
                flag_field("kind", want.kind, got.kind);
            if (got.chan !== want.chan)
                flag_field("table_channel", want.chan, got.chan);
            if (got.raw !== want.raw)
                flag_field("raw_word", want.raw, got.raw);
            if (got.turn !== want.turn)
                flag_field("turn_count", want.turn, got.turn);
            if (got.angle !== want.angle)
                flag_field("angle_position", want.angle, got.angle);
            if (got.valid !== want.valid)
                flag_field("reading_valid", want.valid, got.valid);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int send_idle_pct;
    int recv_idle_pct;
    int beats_sent;

    deframe_predictor model;

    efd_in_if in_ch();
    efd_out_if out_ch();

    encoder_frame_deframer #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("encoder_frame_deframer: mismatch");
        $finish;
    end

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        reading_t got;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                model.take_beat(in_ch.command, in_ch.rx_byte, in_ch.query_channel);
            if (out_ch.valid && out_ch.ready)
            begin
                got.kind = out_ch.kind;
                got.chan = out_ch.table_channel;
                got.raw = out_ch.raw_word;
                got.turn = out_ch.turn_count;
                got.angle = out_ch.angle_position;
                got.valid = out_ch.reading_valid;
                model.check_reading(got);
            end
        end
    end

    task automatic send_beat(input logic cmd, input logic [7:0] b, input logic [4:0] q);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.rx_byte <= b;
        in_ch.query_channel <= q;
        beats_sent++;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(CMD_RX_BYTE, b, 5'($urandom_range(0, 31)));
    endtask

    task automatic send_query(input logic [4:0] q);
        send_beat(CMD_QUERY, 8'($urandom_range(0, 255)), q);
    endtask

    task automatic send_frame(input logic [7:0] ch, input logic [31:0] raw,
                              input logic [7:0] tail);
        send_byte(FRAME_HEAD);
        send_byte(ch);
        for (int k = 3; k >= 0; k--)
            send_byte(raw[8*k +: 8]);
        send_byte(tail);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (model.pending_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] offset, input logic [7:0] count);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= CFG_BASE_CHAN;
        cfg_data <= offset;
        @(posedge clk);
        cfg_index <= CFG_CHAN_LIMIT;
        cfg_data <= count;
        @(posedge clk);
        cfg_we <= 1'b0;
        model.offset = offset;
        model.count = count;
    endtask

    function automatic logic [31:0] pick_raw();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return 32'($urandom);
        endcase
    endfunction

    task automatic run_traffic(input int beats);
        int start;
        int sel;
        int n;
        logic [7:0] ch;
        logic [7:0] tail;
        start = beats_sent;
        while (beats_sent - start < beats)
        begin
            sel = $urandom_range(0, 99);
            ch = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 40));
            if (sel < 55)
                send_frame(ch, pick_raw(), FRAME_TAIL);
            else if (sel < 65)
            begin
                tail = 8'($urandom_range(0, 255));
                if (tail == FRAME_TAIL)
                    tail = 8'h00;
                send_frame(ch, pick_raw(), tail);
            end
            else if (sel < 82)
                send_query(5'($urandom_range(0, 31)));
            else if (sel < 94)
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    case ($urandom_range(0, 3))
                        0: send_byte(FRAME_HEAD);
                        1: send_byte(FRAME_TAIL);
                        default: send_byte(8'($urandom_range(0, 255)));
                    endcase
            end
            else
            begin
                send_byte(FRAME_HEAD);
                n = $urandom_range(0, 4);
                repeat (n)
                    send_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 49) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        logic [7:0] offsets [PHASES];
        logic [7:0] counts [PHASES];
        offsets = '{8'd0, 8'd255, 8'd31, 8'd22, 8'd0, 8'd7};
        counts = '{8'd255, 8'd255, 8'd1, 8'd10, 8'd0, 8'd32};
        model = new();
        beats_sent = 0;
        send_idle_pct = 19;
        recv_idle_pct = 49;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_BASE_CHAN;
        cfg_data <= 8'h00;
        in_ch.valid <= 1'b0;
        in_ch.command <= CMD_RX_BYTE;
        in_ch.rx_byte <= 8'h00;
        in_ch.query_channel <= 5'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Good frame at the last accepted channel, a bad tail, a flush byte,
        // a channel just past the count, then reads of set and unset entries.
        send_frame(8'd9, 32'hFFFF_FFFF, FRAME_TAIL);
        send_frame(8'd1, 32'h0000_0000, 8'h00);
        send_byte(8'hFF);
        send_frame(CHAN_LIMIT_RESET, 32'h1234_5678, FRAME_TAIL);
        send_query(5'd9);
        send_query(5'd0);
        send_query(5'd31);

        for (int p = 0; p < PHASES; p++)
        begin
            write_config(offsets[p], counts[p]);
            if (p >= 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (p >= 2)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 19;
            end
            run_traffic(PHASE_BEATS);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (model.errors == 0 && model.pending_readings.size() == 0)
            $display("encoder_frame_deframer: match");
        else
        begin
            if (model.pending_readings.size() != 0)
                $display("%0t: %0d expected beats never arrived", $time,
                         model.pending_readings.size());
            $display("encoder_frame_deframer: mismatch");
        end
        $finish;
    end
endmodule
